FILE: rtl/core/ipmc_pkg.sv
package ipmc_pkg;

  // defaults for the top-level parameters
  localparam int MAX_PATTERN_DEF = 64;
  localparam int SYM_COUNT_DEF   = 16;

  // fixed field widths
  localparam int CMD_W   = 2;
  localparam int MASK_W  = 16;
  localparam int INDEX_W = 6;
  localparam int LEN_W   = 7;
  localparam int COUNT_W = 32;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // command codes on the request channel
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TEXT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START = 2'd2;

  // classified operation handed to the back end
  typedef enum logic [1:0] {
    OP_NOP,
    OP_LOAD,
    OP_TEXT,
    OP_START
  } op_kind_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [MASK_W-1:0]  symbol_mask;
    logic [INDEX_W-1:0] pattern_index;
  } in_req_t;

  typedef struct packed {
    logic               match_here;
    logic [COUNT_W-1:0] occurrence_count;
  } out_rsp_t;

  typedef struct packed {
    op_kind_t           kind;
    logic [MASK_W-1:0]  mask;
    logic [INDEX_W-1:0] index;
  } op_t;

  // low bits of the mask field that belong to the alphabet
  function automatic logic [MASK_W-1:0] alpha_mask(input int unsigned size);
    logic [MASK_W-1:0] m;
    m = '0;
    for (int unsigned i = 0; i < MASK_W; i++) begin
      m[i] = (i < size);
    end
    return m;
  endfunction

endpackage

FILE: rtl/core/ipmc_front.sv
module ipmc_front import ipmc_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int SYM_COUNT   = SYM_COUNT_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  in_req_t in_data,
  output logic    op_valid,
  input  logic    op_ready,
  output op_t     op_data
);

  localparam logic [MASK_W-1:0] SymMask = alpha_mask(SYM_COUNT);

  logic valid_r, valid_nxt;
  op_t  op_r, op_nxt;
  logic load;

  // decode the command, drop loads outside the pattern store
  always_comb begin
    op_nxt.mask  = in_data.symbol_mask & SymMask;
    op_nxt.index = in_data.pattern_index;
    unique case (in_data.command)
      CMD_LOAD: begin
        op_nxt.kind = (32'(in_data.pattern_index) < 32'(MAX_PATTERN)) ? OP_LOAD : OP_NOP;
      end
      CMD_TEXT:  op_nxt.kind = OP_TEXT;
      CMD_START: op_nxt.kind = OP_START;
      default:   op_nxt.kind = OP_NOP;
    endcase
  end

  assign in_ready = !valid_r || op_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (op_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op_r <= op_nxt;
    end
  end

  assign op_valid = valid_r;
  assign op_data  = op_r;

endmodule

FILE: rtl/core/ipmc_queue.sv
module ipmc_queue import ipmc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  op_t  push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output op_t  pop_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LastPtr = PTR_W'(QUEUE_DEPTH - 1);

  op_t              slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/ipmc_back.sv
module ipmc_back import ipmc_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int SYM_COUNT   = SYM_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [LEN_W-1:0] cfg_len,
  input  logic             op_valid,
  output logic             op_ready,
  input  op_t              op_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_rsp_t         out_data
);

  localparam int SYM_W = (SYM_COUNT < MASK_W) ? SYM_COUNT : MASK_W;
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int EFF_W = $clog2(MAX_PATTERN + 1);

  logic [SYM_W-1:0]       store_r [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] pmv_r, pmv_nxt;
  logic [COUNT_W-1:0]     total_r, total_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_rsp_t               out_data_r, out_data_nxt;

  logic [EFF_W-1:0]       eff_len;
  logic [IDX_W-1:0]       hit_pos;
  logic [SYM_W-1:0]       sym;
  logic [MAX_PATTERN-1:0] shifted;
  logic                   hit;
  logic                   take;

  // length in force, clamped to one..MAX_PATTERN
  always_comb begin
    if (cfg_len == '0) begin
      eff_len = EFF_W'(1);
    end else if (32'(cfg_len) > 32'(MAX_PATTERN)) begin
      eff_len = EFF_W'(MAX_PATTERN);
    end else begin
      eff_len = EFF_W'(cfg_len);
    end
  end

  assign hit_pos = IDX_W'(eff_len - EFF_W'(1));
  assign sym     = op_data.mask[SYM_W-1:0];

  // shift-and step, one lane per pattern position
  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      shifted[j] = ((j == 0) ? 1'b1 : pmv_r[(j == 0) ? 0 : j - 1])
                   && (32'(j) < 32'(eff_len))
                   && ((store_r[j] & sym) != '0);
    end
  end

  assign op_ready = !out_valid_r || out_ready;
  assign take     = op_valid && op_ready;

  always_comb begin
    pmv_nxt   = pmv_r;
    total_nxt = total_r;
    hit       = 1'b0;
    if (take) begin
      unique case (op_data.kind)
        OP_TEXT: begin
          pmv_nxt = shifted;
          hit     = shifted[hit_pos];
          if (hit && (total_r != '1)) begin
            total_nxt = total_r + COUNT_W'(1);
          end
        end
        OP_START: begin
          pmv_nxt   = '0;
          total_nxt = '0;
        end
        default: begin
        end
      endcase
    end
    out_data_nxt.match_here       = hit;
    out_data_nxt.occurrence_count = total_nxt;
  end

  always_comb begin
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pmv_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pmv_r       <= pmv_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= out_data_nxt;
    end
  end

  // pattern masks, no reset
  always_ff @(posedge clk) begin
    if (take && (op_data.kind == OP_LOAD)) begin
      store_r[IDX_W'(op_data.index)] <= sym;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/core/indeterminate_pattern_match_counter_top.sv
// path: a request passes the front register, a queue slot and the result register before its
//   response is valid, and the response is taken once the result channel is free
// throughput: one request per cycle while the result channel takes each response; the shift-and
//   step over all pattern lanes and the saturating count update are combinational in the back end
// reset: synchronous, active low; clears the partial matches, the count, the queue and the
//   pipeline valids, and sets the pattern length to one; pattern masks are kept as they are
module indeterminate_pattern_match_counter_top import ipmc_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int SYM_COUNT   = SYM_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // request channel
  input  logic             in_valid,
  output logic             in_ready,
  input  in_req_t          in_data,
  // response channel
  output logic             out_valid,
  input  logic             out_ready,
  output out_rsp_t         out_data,
  // pattern length register
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data
);

  // pattern length as written; clamping is done in the back end
  logic [LEN_W-1:0] cfg_len_r, cfg_len_nxt;

  // front to queue
  logic fq_valid, fq_ready;
  op_t  fq_data;

  // queue to back
  logic qb_valid, qb_ready;
  op_t  qb_data;

  assign cfg_len_nxt = cfg_wr_en ? cfg_wr_data : cfg_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r <= LEN_W'(1);
    end else begin
      cfg_len_r <= cfg_len_nxt;
    end
  end

  // front: takes each request, masks it to the alphabet and classifies it
  ipmc_front #(
    .MAX_PATTERN (MAX_PATTERN),
    .SYM_COUNT   (SYM_COUNT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .op_valid (fq_valid),
    .op_ready (fq_ready),
    .op_data  (fq_data)
  );

  // short queue so that front and back stall on their own
  ipmc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  // back: pattern store, shift-and vector, count and result register;
  // every operation, loads included, runs here in order
  ipmc_back #(
    .MAX_PATTERN (MAX_PATTERN),
    .SYM_COUNT   (SYM_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_len   (cfg_len_r),
    .op_valid  (qb_valid),
    .op_ready  (qb_ready),
    .op_data   (qb_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
